// ===== rtl/bptc_pkg.sv =====
// Shared widths, payload types and register indexes for the barometric compensation block.
package bptc_pkg;

   // Default oversampling scale factors
   localparam int PRESSURE_SCALE_DEF = 253952;
   localparam int TEMP_SCALE_DEF     = 524288;

   localparam int RAW_W    = 24;   // raw readings
   localparam int Q_FRAC   = 30;   // fraction bits of the fixed-point datapath
   localparam int SC_W     = 37;   // scaled readings, Q30 signed
   localparam int A_W      = 52;   // innermost Horner terms
   localparam int B_W      = 57;   // middle Horner terms
   localparam int P_W      = 64;   // pressure sum
   localparam int T_W      = 48;   // temperature sum
   localparam int PRESS_W  = 32;
   localparam int TEMP_W   = 16;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [63:0] Q_BIAS = (64'd1 << Q_FRAC) - 64'd1;

   typedef enum logic [2:0] {
      REG_C00       = 3'd0,
      REG_C10       = 3'd1,
      REG_C20       = 3'd2,
      REG_C30       = 3'd3,
      REG_C01       = 3'd4,
      REG_C11       = 3'd5,
      REG_C21       = 3'd6,
      REG_TEMP_PAIR = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_pressure;
      logic signed [RAW_W-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [PRESS_W-1:0] pressure_pa;
      logic signed [TEMP_W-1:0]  temperature_c;
   } rsp_type;

endpackage

// ===== rtl/bptc_scale.sv =====
// Pipelined division of a raw reading by a constant scale, giving a Q30 value.
module bptc_scale #(
   parameter int SCALE = bptc_pkg::PRESSURE_SCALE_DEF
) (
   input  logic                                 clock,
   input  logic signed [bptc_pkg::RAW_W-1:0]    raw,
   output logic signed [bptc_pkg::SC_W-1:0]     scaled
);

   localparam int MW    = bptc_pkg::RAW_W;
   localparam int SHIFT = bptc_pkg::Q_FRAC + bptc_pkg::RAW_W - 1;
   localparam logic [63:0] RECIP = (64'd1 << SHIFT) / 64'(SCALE);
   localparam int RW    = $clog2(RECIP + 64'd1);
   localparam int RL    = RW / 2;
   localparam int RH    = RW - RL;
   localparam int QW    = RW + 1;
   localparam int REM_W = $clog2(SCALE) + 2;
   localparam int EW    = (QW > bptc_pkg::SC_W) ? QW : bptc_pkg::SC_W;
   localparam logic [REM_W-1:0] SCALE_R = REM_W'(SCALE);
   localparam logic [RL-1:0] RECIP_LO = RECIP[RL-1:0];
   localparam logic [RH-1:0] RECIP_HI = RECIP[RW-1:RL];

   logic [MW-1:0]          raw_u;
   logic [MW-1:0]          mag;
   logic [MW+RL-1:0]       plo_in, plo_ff;
   logic [MW+RH-1:0]       phi_in, phi_ff;
   logic                   neg1_ff, neg2_ff, neg3_ff;
   logic [MW+RW-1:0]       sum;
   logic [QW-1:0]          q0_in, q0_ff, q1_ff;
   logic [REM_W-1:0]       low_in, low_ff;
   logic [REM_W-1:0]       rem;
   logic                   inc;
   logic [EW-1:0]          qe;
   logic signed [bptc_pkg::SC_W-1:0] qs;
   logic signed [bptc_pkg::SC_W-1:0] out_in, out_ff;

   // magnitude times the reciprocal, in two partial products
   always_comb begin
      raw_u  = $unsigned(raw);
      mag    = raw_u[MW-1] ? (~raw_u + 1'b1) : raw_u;
      plo_in = mag * RECIP_LO;
      phi_in = mag * RECIP_HI;
   end

   // estimate is the quotient or one below it
   always_comb begin
      sum   = {phi_ff, RL'(0)} + (MW+RW)'(plo_ff);
      q0_in = sum[MW+RW-1:bptc_pkg::RAW_W-1];
   end

   // low bits of estimate times scale are enough to recover the remainder
   assign low_in = q0_ff[REM_W-1:0] * SCALE_R;

   always_comb begin
      rem    = REM_W'(0) - low_ff;
      inc    = (rem >= SCALE_R);
      qe     = EW'(q1_ff) + EW'(inc);
      qs     = $signed({1'b0, qe[bptc_pkg::SC_W-2:0]});
      out_in = neg3_ff ? -qs : qs;
   end

   always_ff @(posedge clock) begin
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      neg1_ff <= raw_u[MW-1];
      q0_ff   <= q0_in;
      neg2_ff <= neg1_ff;
      low_ff  <= low_in;
      q1_ff   <= q0_ff;
      neg3_ff <= neg2_ff;
      out_ff  <= out_in;
   end

   assign scaled = out_ff;

endmodule

// ===== rtl/bptc_lin.sv =====
// Two-stage linear term: offset plus coefficient times a Q30 value.
module bptc_lin #(
   parameter int KW = 16,
   parameter int XW = bptc_pkg::SC_W,
   parameter int OW = bptc_pkg::A_W
) (
   input  logic                  clock,
   input  logic signed [KW-1:0]  k,
   input  logic signed [XW-1:0]  x,
   input  logic signed [OW-1:0]  off,
   output logic signed [OW-1:0]  y
);

   logic signed [KW+XW-1:0] prod_in, prod_ff;
   logic signed [OW-1:0]    y_in, y_ff;

   assign prod_in = k * x;
   assign y_in    = OW'(prod_ff) + off;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      y_ff    <= y_in;
   end

   assign y = y_ff;

endmodule

// ===== rtl/bptc_mulq.sv =====
// Four-stage Q30 by Q30 multiply, truncated toward zero, plus an offset.
module bptc_mulq #(
   parameter int AW = bptc_pkg::SC_W,
   parameter int BW = bptc_pkg::A_W,
   parameter int OW = bptc_pkg::B_W
) (
   input  logic                  clock,
   input  logic signed [AW-1:0]  a,
   input  logic signed [BW-1:0]  b,
   input  logic signed [OW-1:0]  off,
   output logic signed [OW-1:0]  y
);

   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int FW = AW + BW;

   logic signed [AL:0]          a_lo;
   logic signed [AH-1:0]        a_hi;
   logic signed [BL:0]          b_lo;
   logic signed [BH-1:0]        b_hi;
   logic signed [AL+BL+1:0]     pll_in, pll_ff;
   logic signed [AL+BH:0]       plh_in, plh_ff;
   logic signed [AH+BL:0]       phl_in, phl_ff;
   logic signed [AH+BH-1:0]     phh_in, phh_ff;
   logic signed [FW-1:0]        full_in, full_ff;
   logic signed [FW-1:0]        rnd;
   logic signed [OW-1:0]        tr_in, tr_ff;
   logic signed [OW-1:0]        y_in, y_ff;

   // split both operands; low halves are taken as unsigned
   always_comb begin
      a_lo   = $signed({1'b0, a[AL-1:0]});
      a_hi   = $signed(a[AW-1:AL]);
      b_lo   = $signed({1'b0, b[BL-1:0]});
      b_hi   = $signed(b[BW-1:BL]);
      pll_in = a_lo * b_lo;
      plh_in = a_lo * b_hi;
      phl_in = a_hi * b_lo;
      phh_in = a_hi * b_hi;
   end

   assign full_in = (FW'(phh_ff) <<< (AL + BL)) + (FW'(phl_ff) <<< AL)
                  + (FW'(plh_ff) <<< BL) + FW'(pll_ff);

   // bias negative products so the shift truncates toward zero
   always_comb begin
      rnd   = full_ff + (full_ff[FW-1] ? $signed(FW'(bptc_pkg::Q_BIAS)) : $signed(FW'(0)));
      tr_in = OW'($signed(rnd[FW-1:bptc_pkg::Q_FRAC]));
   end

   assign y_in = tr_ff + off;

   always_ff @(posedge clock) begin
      pll_ff  <= pll_in;
      plh_ff  <= plh_in;
      phl_ff  <= phl_in;
      phh_ff  <= phh_in;
      full_ff <= full_in;
      tr_ff   <= tr_in;
      y_ff    <= y_in;
   end

   assign y = y_ff;

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
//
// Use: a word of raw pressure and raw temperature (24-bit signed each) is
// taken on req_data at each rising edge where start is high and busy low.
// busy is low whenever reset is low, so one word can be taken every cycle.
// Each word gives one result word on rsp_data, shown for exactly one cycle
// with rsp_strobe high, once it has passed through the stages named below.
// The depth is set by the constant divider (4 stages), the linear terms
// (2), two Q30 multiply-add units in series (4 each), the pressure sum (1)
// and the rounding and saturating output register (1).
// Results leave in input order; the receiver cannot stall, so the pipeline
// never holds. Coefficients are written over the APB port (psel, penable,
// pwrite, paddr, pwdata, prdata, pready); register i sits at byte address
// 4*i, pready is always high and reads return the stored value.
// Reset clears the coefficient registers and all in-flight words; no
// result is shown until a new word has been taken.
module baro_pressure_temp_compensation #(
   parameter int PRESSURE_SCALE = bptc_pkg::PRESSURE_SCALE_DEF,
   parameter int TEMP_SCALE     = bptc_pkg::TEMP_SCALE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bptc_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output bptc_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bptc_pkg::CSR_AW-1:0]       paddr,
   input  logic [bptc_pkg::CSR_DW-1:0]       pwdata,
   output logic [bptc_pkg::CSR_DW-1:0]       prdata,
   output logic                              pready
);

   localparam int SCALE_LAT = 4;
   localparam int LIN_LAT   = 2;
   localparam int MULQ_LAT  = 4;
   localparam int LATENCY   = SCALE_LAT + LIN_LAT + 2 * MULQ_LAT + 2;
   localparam int SC_DLY    = LIN_LAT + MULQ_LAT;
   localparam int T_DLY     = 2 * MULQ_LAT + 1;

   localparam int SC_W  = bptc_pkg::SC_W;
   localparam int A_W   = bptc_pkg::A_W;
   localparam int B_W   = bptc_pkg::B_W;
   localparam int P_W   = bptc_pkg::P_W;
   localparam int T_W   = bptc_pkg::T_W;
   localparam int QF    = bptc_pkg::Q_FRAC;
   localparam int PQ_W  = P_W - QF;
   localparam int TQ_W  = T_W - QF;
   localparam int PR_W  = bptc_pkg::PRESS_W;
   localparam int TE_W  = bptc_pkg::TEMP_W;

   // configuration registers
   logic [19:0] coef_c00_ff, coef_c10_ff;
   logic [15:0] coef_c20_ff, coef_c30_ff, coef_c01_ff, coef_c11_ff, coef_c21_ff;
   logic [23:0] temp_coef_pair_ff;
   logic        cfg_wr;
   bptc_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign busy      = reset;
   assign cfg_wr    = psel && penable && pwrite;
   assign csr_index = bptc_pkg::reg_index_type'(paddr[bptc_pkg::CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_c00_ff       <= '0;
         coef_c10_ff       <= '0;
         coef_c20_ff       <= '0;
         coef_c30_ff       <= '0;
         coef_c01_ff       <= '0;
         coef_c11_ff       <= '0;
         coef_c21_ff       <= '0;
         temp_coef_pair_ff <= '0;
      end else if (cfg_wr) begin
         case (csr_index)
            bptc_pkg::REG_C00:       coef_c00_ff       <= pwdata[19:0];
            bptc_pkg::REG_C10:       coef_c10_ff       <= pwdata[19:0];
            bptc_pkg::REG_C20:       coef_c20_ff       <= pwdata[15:0];
            bptc_pkg::REG_C30:       coef_c30_ff       <= pwdata[15:0];
            bptc_pkg::REG_C01:       coef_c01_ff       <= pwdata[15:0];
            bptc_pkg::REG_C11:       coef_c11_ff       <= pwdata[15:0];
            bptc_pkg::REG_C21:       coef_c21_ff       <= pwdata[15:0];
            bptc_pkg::REG_TEMP_PAIR: temp_coef_pair_ff <= pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bptc_pkg::REG_C00:       prdata = 32'(coef_c00_ff);
         bptc_pkg::REG_C10:       prdata = 32'(coef_c10_ff);
         bptc_pkg::REG_C20:       prdata = 32'(coef_c20_ff);
         bptc_pkg::REG_C30:       prdata = 32'(coef_c30_ff);
         bptc_pkg::REG_C01:       prdata = 32'(coef_c01_ff);
         bptc_pkg::REG_C11:       prdata = 32'(coef_c11_ff);
         bptc_pkg::REG_C21:       prdata = 32'(coef_c21_ff);
         bptc_pkg::REG_TEMP_PAIR: prdata = 32'(temp_coef_pair_ff);
         default:                 prdata = '0;
      endcase
   end

   // coefficients and their Q30 offsets
   logic signed [19:0] c00, c10;
   logic signed [15:0] c20, c30, c01, c11, c21;
   logic signed [11:0] c0, c1;
   logic signed [A_W-1:0] off_a, off_d;
   logic signed [B_W-1:0] off_b, off_e;
   logic signed [P_W-1:0] off_p1, off_p2;
   logic signed [T_W-1:0] off_t;

   always_comb begin
      c00    = $signed(coef_c00_ff);
      c10    = $signed(coef_c10_ff);
      c20    = $signed(coef_c20_ff);
      c30    = $signed(coef_c30_ff);
      c01    = $signed(coef_c01_ff);
      c11    = $signed(coef_c11_ff);
      c21    = $signed(coef_c21_ff);
      c0     = $signed(temp_coef_pair_ff[23:12]);
      c1     = $signed(temp_coef_pair_ff[11:0]);
      off_a  = A_W'(c20) <<< QF;
      off_d  = A_W'(c11) <<< QF;
      off_b  = B_W'(c10) <<< QF;
      off_e  = B_W'(c01) <<< QF;
      off_p1 = P_W'(c00) <<< QF;
      off_p2 = '0;
      off_t  = T_W'(c0) <<< (QF - 1);   // c0/2 in Q30
   end

   // valid bits travel alongside the datapath
   logic [LATENCY-1:0] valid_ff, valid_in;

   assign valid_in = {valid_ff[LATENCY-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // datapath
   logic signed [SC_W-1:0] psc, tsc;
   logic signed [A_W-1:0]  a_term, d_term;
   logic signed [T_W-1:0]  t_term;
   logic signed [B_W-1:0]  b_term, e_term;
   logic signed [P_W-1:0]  p1_term, p2_term;
   logic signed [SC_W-1:0] psc_dly_ff [SC_DLY];
   logic signed [SC_W-1:0] tsc_dly_ff [SC_DLY];
   logic signed [T_W-1:0]  t_dly_ff   [T_DLY];
   logic signed [P_W-1:0]  psum_in, psum_ff;

   bptc_scale #(.SCALE(PRESSURE_SCALE)) u_scale_p (
      .clock  (clock),
      .raw    (req_data.raw_pressure),
      .scaled (psc)
   );

   bptc_scale #(.SCALE(TEMP_SCALE)) u_scale_t (
      .clock  (clock),
      .raw    (req_data.raw_temperature),
      .scaled (tsc)
   );

   bptc_lin #(.KW(16), .XW(SC_W), .OW(A_W)) u_lin_a (
      .clock (clock), .k (c30), .x (psc), .off (off_a), .y (a_term)
   );

   bptc_lin #(.KW(16), .XW(SC_W), .OW(A_W)) u_lin_d (
      .clock (clock), .k (c21), .x (psc), .off (off_d), .y (d_term)
   );

   bptc_lin #(.KW(12), .XW(SC_W), .OW(T_W)) u_lin_t (
      .clock (clock), .k (c1), .x (tsc), .off (off_t), .y (t_term)
   );

   bptc_mulq #(.AW(SC_W), .BW(A_W), .OW(B_W)) u_mulq_b (
      .clock (clock), .a (psc_dly_ff[LIN_LAT-1]), .b (a_term), .off (off_b), .y (b_term)
   );

   bptc_mulq #(.AW(SC_W), .BW(A_W), .OW(B_W)) u_mulq_e (
      .clock (clock), .a (psc_dly_ff[LIN_LAT-1]), .b (d_term), .off (off_e), .y (e_term)
   );

   bptc_mulq #(.AW(SC_W), .BW(B_W), .OW(P_W)) u_mulq_p1 (
      .clock (clock), .a (psc_dly_ff[SC_DLY-1]), .b (b_term), .off (off_p1), .y (p1_term)
   );

   bptc_mulq #(.AW(SC_W), .BW(B_W), .OW(P_W)) u_mulq_p2 (
      .clock (clock), .a (tsc_dly_ff[SC_DLY-1]), .b (e_term), .off (off_p2), .y (p2_term)
   );

   assign psum_in = p1_term + p2_term;

   always_ff @(posedge clock) begin
      psc_dly_ff[0] <= psc;
      tsc_dly_ff[0] <= tsc;
      for (int i = 1; i < SC_DLY; i++) begin
         psc_dly_ff[i] <= psc_dly_ff[i-1];
         tsc_dly_ff[i] <= tsc_dly_ff[i-1];
      end
      t_dly_ff[0] <= t_term;
      for (int i = 1; i < T_DLY; i++) begin
         t_dly_ff[i] <= t_dly_ff[i-1];
      end
      psum_ff <= psum_in;
   end

   // truncate toward zero, then saturate
   logic signed [P_W-1:0]  p_rnd;
   logic signed [T_W-1:0]  t_rnd;
   logic [PQ_W-1:0]        p_int;
   logic [TQ_W-1:0]        t_int;
   bptc_pkg::rsp_type      rsp_in, rsp_ff;

   always_comb begin
      p_rnd = psum_ff + (psum_ff[P_W-1] ? $signed(P_W'(bptc_pkg::Q_BIAS)) : $signed(P_W'(0)));
      t_rnd = t_dly_ff[T_DLY-1]
            + (t_dly_ff[T_DLY-1][T_W-1] ? $signed(T_W'(bptc_pkg::Q_BIAS)) : $signed(T_W'(0)));
      p_int = p_rnd[P_W-1:QF];
      t_int = t_rnd[T_W-1:QF];
      if (p_int[PQ_W-1:PR_W-1] == {(PQ_W-PR_W+1){p_int[PR_W-1]}}) begin
         rsp_in.pressure_pa = $signed(p_int[PR_W-1:0]);
      end else begin
         rsp_in.pressure_pa = p_int[PQ_W-1] ? $signed({1'b1, {(PR_W-1){1'b0}}})
                                            : $signed({1'b0, {(PR_W-1){1'b1}}});
      end
      if (t_int[TQ_W-1:TE_W-1] == {(TQ_W-TE_W+1){t_int[TE_W-1]}}) begin
         rsp_in.temperature_c = $signed(t_int[TE_W-1:0]);
      end else begin
         rsp_in.temperature_c = t_int[TQ_W-1] ? $signed({1'b1, {(TE_W-1){1'b0}}})
                                              : $signed({1'b0, {(TE_W-1){1'b1}}});
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = valid_ff[LATENCY-1];

`ifndef NO_ASSERTIONS
   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted word gave no result");

   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without an accepted word");

   a_c00_wr: assert property (@(posedge clock) disable iff (reset)
      (cfg_wr && (csr_index == bptc_pkg::REG_C00)) |=> (coef_c00_ff == $past(pwdata[19:0])))
      else $error("coef_c00 write lost");

   a_tpair_wr: assert property (@(posedge clock) disable iff (reset)
      (cfg_wr && (csr_index == bptc_pkg::REG_TEMP_PAIR))
         |=> (temp_coef_pair_ff == $past(pwdata[23:0])))
      else $error("temp_coef_pair write lost");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the barometric pressure and temperature compensation block.
`timescale 1ns / 100ps

module tb;

   localparam int REG_WIDTH [8] = '{20, 20, 16, 16, 16, 16, 16, 24};
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 24;   // pipeline is 16 deep

   // Expected compensated readings, worked out from the coefficient copy.
   class compensation_scoreboard;
      bptc_pkg::rsp_type pending_readings[$];
      logic [23:0]       coef [8];
      int                mismatches;

      function new();
         foreach (coef[i]) coef[i] = '0;
         mismatches = 0;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function void set_coef(int idx, logic [31:0] val);
         coef[idx] = 24'(val & ((32'd1 << REG_WIDTH[idx]) - 32'd1));
      endfunction

      function longint field_signed(logic [23:0] v, int w);
         logic [23:0] m;
         longint      x;
         m = v & ((24'd1 << w) - 24'd1);
         x = m;
         if (m[w-1]) x = x - (64'sd1 << w);
         return x;
      endfunction

      function longint sum_sat(longint a, longint b);
         longint s;
         s = a + b;
         if (!a[63] && !b[63] && s[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
         if (a[63] && b[63] && !s[63]) return 64'sh8000_0000_0000_0000;
         return s;
      endfunction

      // Q30 x Q30: exact product, magnitude shifted down, clamped
      function longint q30_mul(longint a, longint b);
         logic [63:0]  x, y;
         logic [127:0] prod;
         longint       r;
         x = a[63] ? -a : a;
         y = b[63] ? -b : b;
         prod = {64'd0, x} * {64'd0, y};
         prod = prod >> 30;
         if (prod > 128'h7FFF_FFFF_FFFF_FFFF) prod = 128'h7FFF_FFFF_FFFF_FFFF;
         r = prod[63:0];
         return (a[63] ^ b[63]) ? -r : r;
      endfunction

      function longint to_q30(longint raw, longint scale);
         logic [63:0] m;
         longint      r;
         m = raw[63] ? -raw : raw;
         m = (m << 30) / scale;
         r = m;
         return raw[63] ? -r : r;
      endfunction

      function longint q30_to_whole(longint v, longint lo, longint hi);
         logic [63:0] m;
         longint      r;
         m = v[63] ? -v : v;
         m = m >> 30;
         r = m;
         if (v[63]) r = -r;
         if (r < lo) return lo;
         if (r > hi) return hi;
         return r;
      endfunction

      function bptc_pkg::rsp_type predict_compensation(bptc_pkg::req_type r);
         longint            psc, tsc, one, t, a, b, d, e, p;
         longint            c00, c10, c20, c30, c01, c11, c21, c0, c1;
         bptc_pkg::rsp_type res;
         longint            pv, tv;
         one = 64'sd1 << 30;
         psc = to_q30(longint'($signed(r.raw_pressure)), bptc_pkg::PRESSURE_SCALE_DEF);
         tsc = to_q30(longint'($signed(r.raw_temperature)), bptc_pkg::TEMP_SCALE_DEF);
         c00 = field_signed(coef[bptc_pkg::REG_C00], 20);
         c10 = field_signed(coef[bptc_pkg::REG_C10], 20);
         c20 = field_signed(coef[bptc_pkg::REG_C20], 16);
         c30 = field_signed(coef[bptc_pkg::REG_C30], 16);
         c01 = field_signed(coef[bptc_pkg::REG_C01], 16);
         c11 = field_signed(coef[bptc_pkg::REG_C11], 16);
         c21 = field_signed(coef[bptc_pkg::REG_C21], 16);
         c0  = field_signed(coef[bptc_pkg::REG_TEMP_PAIR] >> 12, 12);
         c1  = field_signed(coef[bptc_pkg::REG_TEMP_PAIR], 12);

         t = sum_sat(c0 * (one / 2), c1 * tsc);
         a = sum_sat(c20 * one, c30 * psc);
         b = sum_sat(c10 * one, q30_mul(psc, a));
         d = sum_sat(c11 * one, c21 * psc);
         e = sum_sat(c01 * one, q30_mul(psc, d));
         p = sum_sat(c00 * one, q30_mul(psc, b));
         p = sum_sat(p, q30_mul(tsc, e));

         pv = q30_to_whole(p, -64'sd2147483648, 64'sd2147483647);
         tv = q30_to_whole(t, -64'sd32768, 64'sd32767);
         res.pressure_pa   = pv[31:0];
         res.temperature_c = tv[15:0];
         return res;
      endfunction

      function void note_reading(bptc_pkg::req_type r);
         pending_readings.push_back(predict_compensation(r));
      endfunction

      function void check_reading(bptc_pkg::rsp_type got);
         bptc_pkg::rsp_type want;
         if (pending_readings.size() == 0) begin
            report($sformatf("unexpected word p=%0d t=%0d",
                             got.pressure_pa, got.temperature_c));
            return;
         end
         want = pending_readings.pop_front();
         if (got.pressure_pa !== want.pressure_pa)
            report($sformatf("pressure_pa expected %0d, got %0d",
                             want.pressure_pa, got.pressure_pa));
         if (got.temperature_c !== want.temperature_c)
            report($sformatf("temperature_c expected %0d, got %0d",
                             want.temperature_c, got.temperature_c));
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   bptc_pkg::req_type             req_data;
   logic                          rsp_strobe;
   bptc_pkg::rsp_type             rsp_data;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [bptc_pkg::CSR_AW-1:0]   paddr;
   logic [bptc_pkg::CSR_DW-1:0]   pwdata;
   logic [bptc_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;

   compensation_scoreboard comp = new();
   logic [31:0]            coef_plan [8];
   bit                     idling_on = 1'b1;
   int                     cycles = 0;

   baro_pressure_temp_compensation uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // monitor: all sampling on the edge, before the design's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready)
            comp.set_coef(paddr >> 2, pwdata);
         if (start && !busy)
            comp.note_reading(req_data);
         if (rsp_strobe)
            comp.check_reading(rsp_data);
      end
   end

   task automatic send_reading(input bptc_pkg::req_type r);
      while (idling_on && $urandom_range(99) < 29) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (comp.pending_readings.size() != 0) @(posedge clock);
   endtask

   // setup and access for the write, then the same for a read back;
   // the bus is left selected so the next transfer can follow directly
   task automatic program_coef(input bptc_pkg::reg_index_type idx, input logic [31:0] val);
      logic [31:0] mask;
      mask    = (32'd1 << REG_WIDTH[idx]) - 32'd1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) != (val & mask))
         comp.report($sformatf("register %s read %h, wrote %h",
                               idx.name(), prdata & mask, val & mask));
   endtask

   task automatic program_all();
      for (int i = 0; i < 8; i++)
         program_coef(bptc_pkg::reg_index_type'(i), coef_plan[i]);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bptc_pkg::req_type make_reading(logic [23:0] p, logic [23:0] t);
      bptc_pkg::req_type r;
      r.raw_pressure    = p;
      r.raw_temperature = t;
      return r;
   endfunction

   function automatic logic [31:0] extreme_bits(int w);
      case ($urandom_range(3))
         0:       return (32'd1 << (w - 1)) - 32'd1;
         1:       return 32'd1 << (w - 1);
         2:       return 32'd0;
         default: return (32'd1 << w) - 32'd1;
      endcase
   endfunction

   function automatic logic [23:0] edge_value();
      case ($urandom_range(4))
         0:       return 24'h800000;
         1:       return 24'h7FFFFF;
         2:       return 24'h000000;
         3:       return 24'hFFFFFF;
         default: return 24'h000001;
      endcase
   endfunction

   // 0: full random with junk above the width, 1: extremes, 2: modest values
   function automatic void plan_coefs(int mode);
      int          span, c0, c1;
      logic [31:0] hi, lo;
      for (int i = 0; i < 7; i++) begin
         case (mode)
            0: coef_plan[i] = $urandom;
            1: coef_plan[i] = extreme_bits(REG_WIDTH[i]);
            default: begin
               span = 1 << (REG_WIDTH[i] - 5);
               coef_plan[i] = $urandom_range(0, 2 * span - 1) - span;
            end
         endcase
      end
      case (mode)
         0: coef_plan[bptc_pkg::REG_TEMP_PAIR] = $urandom;
         1: begin
            hi = extreme_bits(12);
            lo = extreme_bits(12);
            coef_plan[bptc_pkg::REG_TEMP_PAIR] = {8'h00, hi[11:0], lo[11:0]};
         end
         default: begin
            c0 = $urandom_range(0, 255) - 128;
            c1 = $urandom_range(0, 255) - 128;
            coef_plan[bptc_pkg::REG_TEMP_PAIR] = {8'h00, c0[11:0], c1[11:0]};
         end
      endcase
   endfunction

   function automatic bptc_pkg::req_type random_reading();
      int                k, p, t;
      bptc_pkg::req_type r;
      k = $urandom_range(9);
      if (k < 6) begin
         r.raw_pressure    = $urandom;
         r.raw_temperature = $urandom;
      end else if (k < 8) begin
         // plausible sensor range
         p = $urandom_range(0, 2 ** 22 - 1) - 2 ** 21;
         t = $urandom_range(0, 2 ** 21 - 1) - 2 ** 20;
         r.raw_pressure    = p[23:0];
         r.raw_temperature = t[23:0];
      end else if (k == 8) begin
         r.raw_pressure    = edge_value();
         r.raw_temperature = edge_value();
      end else begin
         r.raw_pressure    = edge_value();
         r.raw_temperature = $urandom;
      end
      return r;
   endfunction

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coefficients still at reset: everything reads zero
      send_reading(make_reading(24'h000000, 24'h000000));
      send_reading(make_reading(24'h7FFFFF, 24'h7FFFFF));
      send_reading(make_reading(24'h800000, 24'h800000));
      wait_drained();

      // typical calibration set
      coef_plan = '{32'd80000, -32'd50000, -32'd4000, -32'd150,
                    -32'd2000, 32'd900, 32'd50, 32'h000C8EFC};
      program_all();
      send_reading(make_reading(24'h000000, 24'h000000));
      send_reading(make_reading(24'h000001, 24'h000001));
      send_reading(make_reading(24'hFFFFFF, 24'hFFFFFF));
      send_reading(make_reading(24'h7FFFFF, 24'h800000));
      send_reading(make_reading(24'h800000, 24'h7FFFFF));
      send_reading(make_reading(-24'sd3000000, 24'sd300000));
      send_reading(make_reading(24'sd1500000, -24'sd200000));
      send_reading(make_reading(24'sd253952, 24'sd524288));
      wait_drained();

      // all positive limits: temperature saturates high when the raw temperature is at its maximum
      coef_plan = '{32'h7FFFF, 32'h7FFFF, 32'h7FFF, 32'h7FFF,
                    32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FF7FF};
      program_all();
      send_reading(make_reading(24'h7FFFFF, 24'h7FFFFF));
      send_reading(make_reading(24'h800000, 24'h800000));
      send_reading(make_reading(24'h7FFFFF, 24'h800000));
      send_reading(make_reading(24'h800000, 24'h7FFFFF));
      wait_drained();

      // all negative limits, junk in the unused upper bits
      coef_plan = '{32'hFFF80000, 32'hABC80000, 32'h12348000, 32'hFFFF8000,
                    32'h00018000, 32'h80008000, 32'h5A5A8000, 32'hFF800800};
      program_all();
      send_reading(make_reading(24'h7FFFFF, 24'h7FFFFF));
      send_reading(make_reading(24'h800000, 24'h800000));
      send_reading(make_reading(24'h7FFFFF, 24'h800000));
      send_reading(make_reading(24'h800000, 24'h7FFFFF));
      wait_drained();

      for (int ph = 0; ph < 7; ph++) begin
         plan_coefs(ph % 3);
         program_all();
         idling_on = (ph != 3);   // one long back-to-back stretch
         for (int n = 0; n < 100; n++) send_reading(random_reading());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (comp.mismatches == 0 && comp.pending_readings.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
